// ===== src/upe_pkg.sv =====
// ----------------------------------------------------------------------------
// upe_pkg
// Shared types, constants and character classes for the URL port extractor.
// ----------------------------------------------------------------------------
package upe_pkg;

  // Default sizes, used as parameter defaults on the top level
  localparam int MAX_LEN       = 256;
  localparam int SCHEME_WINDOW = 16;
  localparam int MAX_DIGITS    = 10;

  // Result field widths and caps
  localparam int VALUE_W = 34;
  localparam int COUNT_W = 4;
  localparam logic [VALUE_W-1:0] VALUE_CAP = '1;
  localparam logic [COUNT_W-1:0] COUNT_CAP = '1;

  // Characters the scanner looks for
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
  localparam logic [7:0] CH_AT     = 8'h40;  // '@'
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
  localparam logic [7:0] CH_QMARK  = 8'h3F;  // '?'
  localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
  localparam logic [7:0] CH_DOT    = 8'h2E;  // '.'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_EVAL,
    B_DONE
  } back_state_e;

  typedef enum logic [3:0] {
    PH_SCHEME,
    PH_COLON1,
    PH_COLON2,
    PH_USER,
    PH_BRACKET,
    PH_IPV6,
    PH_PSEARCH,
    PH_PCHECK,
    PH_DIGITS
  } scan_phase_e;

  // Job queue status seen by the loader and the scanner
  typedef struct packed {
    logic full;
    logic empty;
  } jobq_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  // Characters allowed in a scheme after its first byte
  function automatic logic is_scheme_char(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
           (c inside {CH_DOT, CH_MINUS, CH_PLUS});
  endfunction

  function automatic logic is_stop(input logic [7:0] c);
    return c inside {CH_SLASH, CH_QMARK, CH_HASH};
  endfunction

endpackage

// ===== src/upe_in_if.sv =====
// ----------------------------------------------------------------------------
// upe_in_if
// Input channel: one URL byte per item, with no-byte and last-byte flags.
// ----------------------------------------------------------------------------
interface upe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] url_byte;
  logic       no_byte;
  logic       last_byte;

  modport source (output valid, url_byte, no_byte, last_byte, input ready);
  modport sink   (input valid, url_byte, no_byte, last_byte, output ready);
endinterface

// ===== src/upe_out_if.sv =====
// ----------------------------------------------------------------------------
// upe_out_if
// Output channel: one port result per URL.
// ----------------------------------------------------------------------------
interface upe_out_if import upe_pkg::*;;
  logic               valid;
  logic               ready;
  logic               port_found;
  logic [VALUE_W-1:0] port_value;
  logic [COUNT_W-1:0] digit_count;
  logic               too_long;
  logic               truncated;

  modport source (output valid, port_found, port_value, digit_count, too_long,
                  truncated, input ready);
  modport sink   (input valid, port_found, port_value, digit_count, too_long,
                  truncated, output ready);
endinterface

// ===== src/upe_ram.sv =====
// ----------------------------------------------------------------------------
// upe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module upe_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 512,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/upe_jobq.sv =====
// ----------------------------------------------------------------------------
// upe_jobq
// Two-entry queue of finished URLs (length and overflow flag), one per bank.
// ----------------------------------------------------------------------------
module upe_jobq import upe_pkg::*; #(
  parameter int Width = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output jobq_status_t     stat_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] entry_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  assign data_o       = entry_q[rptr_q];
  assign stat_o.full  = cnt_q[1];
  assign stat_o.empty = (cnt_q == 2'd0);

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full) else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("job popped from empty queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("job count out of range");

endmodule

// ===== src/upe_front.sv =====
// ----------------------------------------------------------------------------
// upe_front
// Loader: accept bytes, write them into the current bank, close a URL on
// its last item by queueing its length and overflow flag.
// ----------------------------------------------------------------------------
module upe_front import upe_pkg::*; #(
  parameter  int MaxLen = MAX_LEN,
  localparam int LenW   = $clog2(MaxLen + 1),
  localparam int IdxW   = $clog2(MaxLen)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  upe_in_if.sink        in_i,
  input  jobq_status_t  q_stat_i,
  output logic          push_o,
  output logic [LenW:0] job_o,
  output logic          ram_we_o,
  output logic [IdxW:0] ram_waddr_o,
  output logic [7:0]    ram_wdata_o
);

  logic [LenW-1:0] len_q, len_d, len_nx;
  logic            ovf_q, ovf_d, ovf_nx;
  logic            bank_q, bank_d;
  logic            accept;
  logic            has_byte;
  logic            room;

  // Stall only when both banks hold URLs not yet scanned
  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign has_byte   = accept && !in_i.no_byte;
  assign room       = len_q < LenW'(MaxLen);

  always_comb begin
    len_nx = len_q + LenW'(has_byte && room);
    ovf_nx = ovf_q || (has_byte && !room);
    push_o = accept && in_i.last_byte;
    job_o  = {ovf_nx, len_nx};
    len_d  = push_o ? '0 : len_nx;
    ovf_d  = push_o ? 1'b0 : ovf_nx;
    bank_d = bank_q ^ push_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      bank_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      bank_q <= bank_d;
    end
  end

  assign ram_we_o    = has_byte && room;
  assign ram_waddr_o = {bank_q, len_q[IdxW-1:0]};
  assign ram_wdata_o = in_i.url_byte;

endmodule

// ===== src/upe_back.sv =====
// ----------------------------------------------------------------------------
// upe_back
// Scanner: walk the stored URL one byte per fetch/evaluate pair through the
// scheme, user info, IPv6 host, port search and digit phases, then hand the
// result to the output register.
// ----------------------------------------------------------------------------
module upe_back import upe_pkg::*; #(
  parameter  int MaxLen       = MAX_LEN,
  parameter  int SchemeWindow = SCHEME_WINDOW,
  parameter  int MaxDigits    = MAX_DIGITS,
  localparam int LenW         = $clog2(MaxLen + 1),
  localparam int IdxW         = $clog2(MaxLen)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jobq_status_t  q_stat_i,
  input  logic [LenW:0] job_i,
  output logic          pop_o,
  output logic          ram_re_o,
  output logic [IdxW:0] ram_raddr_o,
  input  logic [7:0]    ram_rdata_i,
  upe_out_if.source     out_o
);

  // Accumulator holds up to MaxDigits decimal digits (log2(10) < 10/3)
  localparam int AccW     = (MaxDigits * 10 + 2) / 3 + 1;
  localparam int CntW     = $clog2(MaxDigits + 1);
  localparam int CmpW     = ((LenW > 7) ? LenW : 7) + 1;
  localparam int EvW      = (AccW > VALUE_W) ? AccW : VALUE_W;
  localparam int EcW      = (CntW > COUNT_W) ? CntW : COUNT_W;
  localparam int CountSat = (MaxDigits > 15) ? 15 : MaxDigits;

  function automatic logic [AccW-1:0] calc_sat();
    logic [AccW-1:0] s;
    s = AccW'(1);
    for (int k = 0; k < MaxDigits; k++) begin
      s = s * AccW'(10);
    end
    return s - AccW'(1);
  endfunction

  localparam logic [AccW-1:0] SatValue = calc_sat();

  back_state_e     state_q, state_d;
  scan_phase_e     phase_q, phase_d;
  logic [LenW-1:0] p_q, p_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic            slash0_q, slash0_d;
  logic [AccW-1:0] value_q, value_d;
  logic [CntW-1:0] count_q, count_d;
  logic            toolong_q, toolong_d;
  logic            found_q, found_d;
  logic            bank_q, bank_d;

  logic               out_valid_q, out_valid_d;
  logic               out_found_q, out_found_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  logic               out_toolong_q, out_toolong_d;
  logic               out_trunc_q, out_trunc_d;

  logic [LenW-1:0] n;
  logic            ovf;
  logic [CmpW-1:0] n_c, p_c, lim;
  logic            at_end, past_lim, room3;
  logic [LenW-1:0] p_inc;
  logic [7:0]      b;
  logic            rd;
  logic [AccW-1:0] val_sel;
  logic [EvW-1:0]  val_ext;
  logic [EcW-1:0]  cnt_ext;

  assign n        = job_i[LenW-1:0];
  assign ovf      = job_i[LenW];
  assign n_c      = CmpW'(n);
  assign p_c      = CmpW'(p_q);
  assign lim      = (n_c < CmpW'(SchemeWindow)) ? n_c : CmpW'(SchemeWindow);
  assign at_end   = p_c >= n_c;
  assign past_lim = p_c >= lim;
  assign room3    = (p_c + CmpW'(2)) < lim;
  assign p_inc    = p_q + LenW'(1);
  assign b        = ram_rdata_i;

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    p_d           = p_q;
    pos_d         = pos_q;
    slash0_d      = slash0_q;
    value_d       = value_q;
    count_d       = count_q;
    toolong_d     = toolong_q;
    found_d       = found_q;
    bank_d        = bank_q;
    pop_o         = 1'b0;
    ram_re_o      = 1'b0;
    ram_raddr_o   = {bank_q, p_q[IdxW-1:0]};
    rd            = 1'b0;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_found_d   = out_found_q;
    out_value_d   = out_value_q;
    out_count_d   = out_count_q;
    out_toolong_d = out_toolong_q;
    out_trunc_d   = out_trunc_q;
    val_sel       = toolong_q ? SatValue : value_q;
    val_ext       = EvW'(val_sel);
    cnt_ext       = EcW'(count_q);

    case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          phase_d   = PH_SCHEME;
          p_d       = '0;
          pos_d     = '0;
          slash0_d  = 1'b0;
          value_d   = '0;
          count_d   = '0;
          toolong_d = 1'b0;
          found_d   = 1'b0;
          state_d   = (n == '0) ? B_DONE : B_FETCH;
        end
      end

      B_FETCH: begin
        rd = 1'b1;
        case (phase_q)
          PH_SCHEME: begin
            if (past_lim) begin
              rd      = 1'b0;
              pos_d   = '0;
              p_d     = '0;
              phase_d = PH_USER;
            end
          end
          PH_USER: begin
            if (at_end) begin
              rd      = 1'b0;
              p_d     = pos_q;
              phase_d = PH_BRACKET;
            end
          end
          PH_BRACKET, PH_PCHECK: begin
            if (at_end) begin
              rd      = 1'b0;
              phase_d = PH_PSEARCH;
            end
          end
          PH_IPV6: begin
            if (at_end) begin
              rd      = 1'b0;
              p_d     = pos_q;
              phase_d = PH_PSEARCH;
            end
          end
          PH_PSEARCH: begin
            if (at_end) begin
              rd      = 1'b0;
              found_d = 1'b0;
              state_d = B_DONE;
            end
          end
          PH_DIGITS: begin
            if (at_end) begin
              rd      = 1'b0;
              found_d = 1'b1;
              state_d = B_DONE;
            end
          end
          default: begin
            // colon phases stay inside the scheme window
            rd = 1'b1;
          end
        endcase
        if (rd) begin
          ram_re_o = 1'b1;
          state_d  = B_EVAL;
        end
      end

      B_EVAL: begin
        state_d = B_FETCH;
        case (phase_q)
          PH_SCHEME: begin
            if (p_q == '0) begin
              slash0_d = (b == CH_SLASH);
              p_d      = p_inc;
            end else if (p_q == LenW'(1) && slash0_q && b == CH_SLASH) begin
              pos_d   = LenW'(2);
              p_d     = LenW'(2);
              phase_d = PH_USER;
            end else if (is_scheme_char(b)) begin
              p_d = p_inc;
            end else if (b == CH_COLON && room3) begin
              p_d     = p_inc;
              phase_d = PH_COLON1;
            end else begin
              pos_d   = '0;
              p_d     = '0;
              phase_d = PH_USER;
            end
          end
          PH_COLON1: begin
            if (b == CH_SLASH) begin
              p_d     = p_inc;
              phase_d = PH_COLON2;
            end else begin
              pos_d   = '0;
              p_d     = '0;
              phase_d = PH_USER;
            end
          end
          PH_COLON2: begin
            phase_d = PH_USER;
            if (b == CH_SLASH) begin
              pos_d = p_inc;
              p_d   = p_inc;
            end else begin
              pos_d = '0;
              p_d   = '0;
            end
          end
          PH_USER: begin
            if (b == CH_AT) begin
              pos_d   = p_inc;
              p_d     = p_inc;
              phase_d = PH_BRACKET;
            end else if (is_stop(b)) begin
              p_d     = pos_q;
              phase_d = PH_BRACKET;
            end else begin
              p_d = p_inc;
            end
          end
          PH_BRACKET: begin
            if (b == CH_LBRACK) begin
              p_d     = p_inc;
              phase_d = PH_IPV6;
            end else begin
              phase_d = PH_PSEARCH;
            end
          end
          PH_IPV6: begin
            if (b == CH_RBRACK) begin
              pos_d   = p_inc;
              p_d     = p_inc;
              phase_d = PH_PSEARCH;
            end else begin
              p_d = p_inc;
            end
          end
          PH_PSEARCH: begin
            if (b == CH_COLON) begin
              p_d     = p_inc;
              phase_d = PH_PCHECK;
            end else if (is_stop(b)) begin
              found_d = 1'b0;
              state_d = B_DONE;
            end else begin
              p_d = p_inc;
            end
          end
          PH_PCHECK: begin
            // re-fetch this byte in the phase that owns it
            phase_d = is_digit(b) ? PH_DIGITS : PH_PSEARCH;
          end
          PH_DIGITS: begin
            if (is_stop(b)) begin
              found_d = 1'b1;
              state_d = B_DONE;
            end else if (!is_digit(b)) begin
              found_d = 1'b0;
              state_d = B_DONE;
            end else begin
              p_d = p_inc;
              if (count_q < CntW'(MaxDigits)) begin
                value_d = (value_q << 3) + (value_q << 1) + AccW'(b[3:0]);
                count_d = count_q + CntW'(1);
              end else begin
                toolong_d = 1'b1;
              end
            end
          end
          default: begin
            state_d = B_DONE;
          end
        endcase
      end

      B_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_found_d   = found_q;
          out_trunc_d   = ovf;
          out_toolong_d = found_q && toolong_q;
          if (found_q) begin
            out_value_d = (val_ext > EvW'(VALUE_CAP)) ? VALUE_CAP
                                                      : val_ext[VALUE_W-1:0];
            out_count_d = (cnt_ext > EcW'(COUNT_CAP)) ? COUNT_CAP
                                                      : cnt_ext[COUNT_W-1:0];
          end else begin
            out_value_d = '0;
            out_count_d = '0;
          end
          pop_o   = 1'b1;
          bank_d  = ~bank_q;
          state_d = B_IDLE;
        end
      end

      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      phase_q     <= PH_SCHEME;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      bank_q      <= bank_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q           <= p_d;
    pos_q         <= pos_d;
    slash0_q      <= slash0_d;
    value_q       <= value_d;
    count_q       <= count_d;
    toolong_q     <= toolong_d;
    found_q       <= found_d;
    out_found_q   <= out_found_d;
    out_value_q   <= out_value_d;
    out_count_q   <= out_count_d;
    out_toolong_q <= out_toolong_d;
    out_trunc_q   <= out_trunc_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.port_found  = out_found_q;
  assign out_o.port_value  = out_value_q;
  assign out_o.digit_count = out_count_q;
  assign out_o.too_long    = out_toolong_q;
  assign out_o.truncated   = out_trunc_q;

  a_eval_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_EVAL |-> p_c < n_c) else $error("scan read past URL end");

  a_found_has_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_found_q |-> out_count_q != '0)
    else $error("port found without digits");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |->
      out_value_q == '0 && out_count_q == '0 && !out_toolong_q)
    else $error("empty result carries port data");

  a_toolong_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_toolong_q |-> out_count_q == COUNT_W'(CountSat))
    else $error("too_long without saturated digit count");

endmodule

// ===== src/url_port_extractor_top.sv =====
// ----------------------------------------------------------------------------
// url_port_extractor_top
// Extract the port of a URL that arrives one byte per item; one result per
// URL, which closes on the item that carries last_byte.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Payload
//  in_i     in   valid/ready    url_byte[7:0], no_byte, last_byte
//  out_o    out  valid/ready    port_found, port_value[33:0], digit_count[3:0],
//                               too_long, truncated
//
//  The loader takes one byte per cycle while in_i is not stalled. The scanner
//  visits each byte it needs with a fetch step and an evaluate step on the
//  buffer RAM read port. User info and IPv6 passes can each cover the whole
//  URL, and the port search visits a byte after a ':' twice.
//  The buffer has two banks: the next URL loads while the previous one scans.
//  in_i stalls only while both banks hold URLs waiting for the scanner.
//  The result sits in an output register; the scanner holds its result while
//  out_o is stalled and moves on once the register is free.
//  Reset: control state clears at once; the buffer needs no clearing pass, a
//  fill count per URL bounds every read.
// ----------------------------------------------------------------------------
module url_port_extractor_top import upe_pkg::*; #(
  parameter int MaxLen       = MAX_LEN,
  parameter int SchemeWindow = SCHEME_WINDOW,
  parameter int MaxDigits    = MAX_DIGITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  upe_in_if.sink    in_i,
  upe_out_if.source out_o
);

  localparam int LenW = $clog2(MaxLen + 1);
  localparam int IdxW = $clog2(MaxLen);

  // Queue between loader and scanner: {overflow, length} per finished URL
  jobq_status_t  q_stat;
  logic          q_push;
  logic          q_pop;
  logic [LenW:0] q_wdata;
  logic [LenW:0] q_rdata;

  // Buffer RAM ports, bank bit on top of the byte index
  logic          ram_we;
  logic [IdxW:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [IdxW:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Loader: store bytes, close a URL on its last item
  upe_front #(
    .MaxLen (MaxLen)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .job_o       (q_wdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  // Two-bank URL buffer
  upe_ram #(
    .Width (8),
    .Depth (2 ** (IdxW + 1))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One queue entry per bank in use
  upe_jobq #(
    .Width (LenW + 1)
  ) u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .stat_o (q_stat),
    .data_o (q_rdata)
  );

  // Scanner: walk the stored URL and build the result
  upe_back #(
    .MaxLen       (MaxLen),
    .SchemeWindow (SchemeWindow),
    .MaxDigits    (MaxDigits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .job_i       (q_rdata),
    .pop_o       (q_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_o       (out_o)
  );

endmodule
